>>> hdl/lrcsrp_pkg.sv
// Shared types, constants and the GF(2^8) inverse table of the repair planner.
// No dependencies; every other file of the block imports this package.
package lrcsrp_pkg;

   localparam int IDX_WIDTH      = 7;
   localparam int CFG_WIDTH      = 6;
   localparam int COEF_WIDTH     = 8;
   localparam int DIV_WIDTH      = 6;
   localparam int CSR_ADDR_WIDTH = 4;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int MAX_DATA       = 32;
   localparam logic [8:0] GF_POLY = 9'h11D;

   typedef logic [255:0][COEF_WIDTH-1:0] gf_table_type;

   // Register indexes of the APB port, one 32-bit slot each.
   typedef enum logic [1:0] {
      REG_DATA_BLOCKS     = 2'd0,
      REG_LOCAL_GROUPS    = 2'd1,
      REG_GLOBAL_PARITIES = 2'd2
   } csr_reg_type;

   typedef enum logic [1:0] {
      MODE_DATA,
      MODE_LOCAL,
      MODE_GLOBAL,
      MODE_BAD
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_K,
      ST_CLASSIFY,
      ST_DIV_R,
      ST_EMIT,
      ST_PARITY,
      ST_BAD
   } state_type;

   typedef struct packed {
      logic [CFG_WIDTH-1:0] data_blocks;
      logic [CFG_WIDTH-1:0] local_groups;
      logic [CFG_WIDTH-1:0] global_parities;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic div_k_start;
      logic div_r_start;
      logic nr_load;
      logic mode_load;
      logic group_load;
      logic advance;
      logic push_member;
      logic push_parity;
      logic push_bad;
   } cmd_type;

   typedef struct packed {
      logic     div_done;
      mode_type mode;
      logic     nr_zero;
      logic     k_zero;
      logic     loop_end;
      logic     skip;
      logic     out_free;
   } status_type;

   // Inverse table built from the exponent sequence of generator 2; zero maps to zero.
   function automatic gf_table_type gf_inv_build();
      gf_table_type tbl;
      gf_table_type expv;
      logic [8:0]   x;
      int           i;
      int           j;
      tbl  = '0;
      expv = '0;
      x    = 9'd1;
      for (i = 0; i < 255; i++) begin
         expv[i] = x[7:0];
         x = {x[7:0], 1'b0};
         if (x[8]) begin
            x = x ^ GF_POLY;
         end
      end
      for (i = 0; i < 255; i++) begin
         j = (i == 0) ? 0 : 255 - i;
         tbl[expv[i]] = expv[j];
      end
      return tbl;
   endfunction

   localparam gf_table_type GF_INV_TABLE = gf_inv_build();

endpackage

>>> hdl/lrcsrp_if.sv
// Valid/ready channel interfaces for the failed-index request and the repair pairs.
// Depends on lrcsrp_pkg for field widths.
interface lrcsrp_req_if;
   import lrcsrp_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [IDX_WIDTH-1:0] failed_index;

   modport source (output valid, output failed_index, input ready);
   modport sink   (input valid, input failed_index, output ready);
endinterface

interface lrcsrp_rsp_if;
   import lrcsrp_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [IDX_WIDTH-1:0]  source_index;
   logic [COEF_WIDTH-1:0] coefficient;
   logic                  last;
   logic                  bad_index;

   modport source (output valid, output source_index, output coefficient,
                   output last, output bad_index, input ready);
   modport sink   (input valid, input source_index, input coefficient,
                   input last, input bad_index, output ready);
endinterface

>>> hdl/lrcsrp_div.sv
// Restoring divider, one quotient bit per cycle, for the group-size arithmetic.
// Depends on lrcsrp_pkg.
module lrcsrp_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [lrcsrp_pkg::DIV_WIDTH-1:0] num,
   input  logic [lrcsrp_pkg::DIV_WIDTH-1:0] den,
   output logic                             done,
   output logic [lrcsrp_pkg::DIV_WIDTH-1:0] quot,
   output logic [lrcsrp_pkg::DIV_WIDTH-1:0] rem
);
   import lrcsrp_pkg::*;

   localparam int CNT_W = $clog2(DIV_WIDTH);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIV_WIDTH - 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [DIV_WIDTH-1:0] acc_ff, acc_in;
   logic [DIV_WIDTH-1:0] q_ff, q_in;
   logic [DIV_WIDTH-1:0] d_ff, d_in;
   logic [DIV_WIDTH:0]   trial;
   logic [DIV_WIDTH:0]   diff;
   logic                 fits;

   assign trial = {acc_ff, q_ff[DIV_WIDTH-1]};
   assign diff  = trial - {1'b0, d_ff};
   assign fits  = (trial >= {1'b0, d_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      q_in    = q_ff;
      d_in    = d_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         acc_in  = '0;
         q_in    = num;
         d_in    = den;
      end else if (busy_ff) begin
         acc_in = fits ? diff[DIV_WIDTH-1:0] : trial[DIV_WIDTH-1:0];
         q_in   = {q_ff[DIV_WIDTH-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      q_ff   <= q_in;
      d_ff   <= d_in;
   end

   assign done = done_ff;
   assign quot = q_ff;
   assign rem  = acc_ff;

endmodule

>>> hdl/lrcsrp_csr.sv
// APB-style register file holding the stripe geometry (k, l, g).
// Depends on lrcsrp_pkg.
module lrcsrp_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [lrcsrp_pkg::CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [lrcsrp_pkg::CSR_DATA_WIDTH-1:0] pwdata,
   output logic [lrcsrp_pkg::CSR_DATA_WIDTH-1:0] prdata,
   output logic                                  pready,
   output lrcsrp_pkg::cfg_type                   cfg
);
   import lrcsrp_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic [1:0] reg_sel;
   logic       wr_en;

   assign reg_sel = paddr[3:2];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_DATA_BLOCKS:     cfg_in.data_blocks     = pwdata[CFG_WIDTH-1:0];
            REG_LOCAL_GROUPS:    cfg_in.local_groups    = pwdata[CFG_WIDTH-1:0];
            REG_GLOBAL_PARITIES: cfg_in.global_parities = pwdata[CFG_WIDTH-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_DATA_BLOCKS:     prdata = CSR_DATA_WIDTH'(cfg_ff.data_blocks);
         REG_LOCAL_GROUPS:    prdata = CSR_DATA_WIDTH'(cfg_ff.local_groups);
         REG_GLOBAL_PARITIES: prdata = CSR_DATA_WIDTH'(cfg_ff.global_parities);
         default:             prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.data_blocks     <= CFG_WIDTH'(6);
         cfg_ff.local_groups    <= CFG_WIDTH'(2);
         cfg_ff.global_parities <= CFG_WIDTH'(2);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> hdl/lrcsrp_dp.sv
// Datapath: failed-index register, group arithmetic, pair counter and output register.
// Depends on lrcsrp_pkg, lrcsrp_if and lrcsrp_div.
module lrcsrp_dp (
   input  logic                             clock,
   input  logic                             reset,
   input  lrcsrp_pkg::cfg_type              cfg,
   input  logic [lrcsrp_pkg::IDX_WIDTH-1:0] failed_index,
   input  lrcsrp_pkg::cmd_type              cmd,
   output lrcsrp_pkg::status_type           status,
   lrcsrp_rsp_if.source                     rsp
);
   import lrcsrp_pkg::*;

   logic [IDX_WIDTH-1:0]    ridx_ff;
   logic [DIV_WIDTH-1:0]    nr_ff;
   logic [DIV_WIDTH-1:0]    gidx_ff;
   logic [DIV_WIDTH-1:0]    base_ff;
   logic [DIV_WIDTH-1:0]    cnt_ff, cnt_in;
   mode_type                mode_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [IDX_WIDTH-1:0]    src_ff;
   logic [COEF_WIDTH-1:0]   coef_ff;
   logic                    last_ff;
   logic                    bad_ff;

   logic [CFG_WIDTH-1:0]    k;
   logic [7:0]              total;
   logic [7:0]              ridx_ext;
   mode_type                mode_now;
   logic [DIV_WIDTH-1:0]    div_num, div_den, div_quot, div_rem;
   logic                    div_done;
   logic [DIV_WIDTH-1:0]    gidx_local;
   logic [2*DIV_WIDTH-1:0]  base_prod;
   logic [DIV_WIDTH-1:0]    loop_count;
   logic                    loop_end;
   logic [IDX_WIDTH-1:0]    member;
   logic [7:0]              inv_idx;
   logic                    out_free;
   logic                    push;

   // Clamp k to the supported maximum.
   assign k = (7'(cfg.data_blocks) > 7'(MAX_DATA)) ? CFG_WIDTH'(MAX_DATA) : cfg.data_blocks;

   assign total    = 8'(k) + 8'(cfg.local_groups) + 8'(cfg.global_parities);
   assign ridx_ext = 8'(ridx_ff);

   always_comb begin
      priority if (ridx_ext >= total) begin
         mode_now = MODE_BAD;
      end else if (ridx_ext < 8'(k)) begin
         mode_now = MODE_DATA;
      end else if (ridx_ext < 8'(k) + 8'(cfg.local_groups)) begin
         mode_now = MODE_LOCAL;
      end else begin
         mode_now = MODE_GLOBAL;
      end
   end

   assign div_num = cmd.div_k_start ? k : ridx_ff[DIV_WIDTH-1:0];
   assign div_den = cmd.div_k_start ? cfg.local_groups : nr_ff;

   lrcsrp_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_k_start | cmd.div_r_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot),
      .rem   (div_rem)
   );

   // A lost local parity below k+l keeps gidx*nr below k.
   assign gidx_local = DIV_WIDTH'(ridx_ff - IDX_WIDTH'(k));
   assign base_prod  = gidx_local * nr_ff;

   assign loop_count = (mode_ff == MODE_GLOBAL) ? k : nr_ff;
   assign loop_end   = (cnt_ff == loop_count - 1'b1);
   assign member     = IDX_WIDTH'(base_ff) + IDX_WIDTH'(cnt_ff);
   assign inv_idx    = 8'(ridx_ff ^ IDX_WIDTH'(cnt_ff));

   assign out_free = !rsp_valid_ff || rsp.ready;
   assign push     = cmd.push_member | cmd.push_parity | cmd.push_bad;

   assign cnt_in = cmd.load ? '0 : (cmd.advance ? cnt_ff + 1'b1 : cnt_ff);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (push) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         mode_ff      <= MODE_BAD;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         if (cmd.mode_load) begin
            mode_ff <= mode_now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ridx_ff <= failed_index;
      end
      if (cmd.nr_load) begin
         nr_ff <= (cfg.local_groups == '0) ? '0 : div_quot;
      end
      if (cmd.mode_load) begin
         if (mode_now == MODE_LOCAL) begin
            gidx_ff <= gidx_local;
            base_ff <= base_prod[DIV_WIDTH-1:0];
         end else begin
            gidx_ff <= '0;
            base_ff <= '0;
         end
      end else if (cmd.group_load) begin
         gidx_ff <= div_quot;
         base_ff <= ridx_ff[DIV_WIDTH-1:0] - div_rem;
      end
      if (cmd.push_member) begin
         src_ff  <= member;
         coef_ff <= (mode_ff == MODE_GLOBAL) ? GF_INV_TABLE[inv_idx] : COEF_WIDTH'(1);
         last_ff <= (mode_ff != MODE_DATA) && loop_end;
         bad_ff  <= 1'b0;
      end else if (cmd.push_parity) begin
         src_ff  <= IDX_WIDTH'(k) + IDX_WIDTH'(gidx_ff);
         coef_ff <= COEF_WIDTH'(1);
         last_ff <= 1'b1;
         bad_ff  <= 1'b0;
      end else if (cmd.push_bad) begin
         src_ff  <= '0;
         coef_ff <= '0;
         last_ff <= 1'b1;
         bad_ff  <= 1'b1;
      end
   end

   assign status.div_done = div_done;
   assign status.mode     = mode_now;
   assign status.nr_zero  = (nr_ff == '0);
   assign status.k_zero   = (k == '0);
   assign status.loop_end = loop_end;
   assign status.skip     = (mode_ff == MODE_DATA) && (member == ridx_ff);
   assign status.out_free = out_free;

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.source_index = src_ff;
   assign rsp.coefficient  = coef_ff;
   assign rsp.last         = last_ff;
   assign rsp.bad_index    = bad_ff;

endmodule

>>> hdl/lrcsrp_ctrl.sv
// Sequencer of the repair planner: divisions, classification and pair emission.
// Depends on lrcsrp_pkg.
module lrcsrp_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  lrcsrp_pkg::status_type status,
   output lrcsrp_pkg::cmd_type    cmd
);
   import lrcsrp_pkg::*;

   state_type state_ff, state_in;
   logic      step;
   // Remember whether the plan in flight is a data-block plan.
   logic      data_mode_ff, data_mode_in;

   assign step = status.skip || status.out_free;

   assign data_mode_in = (state_ff == ST_CLASSIFY) ? (status.mode == MODE_DATA) : data_mode_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DIV_K;
         end
         ST_DIV_K: begin
            if (status.div_done) state_in = ST_CLASSIFY;
         end
         ST_CLASSIFY: begin
            unique case (status.mode)
               MODE_BAD:    state_in = ST_BAD;
               MODE_DATA:   state_in = status.nr_zero ? ST_PARITY : ST_DIV_R;
               MODE_LOCAL:  state_in = status.nr_zero ? ST_IDLE : ST_EMIT;
               MODE_GLOBAL: state_in = status.k_zero ? ST_IDLE : ST_EMIT;
               default:     state_in = ST_IDLE;
            endcase
         end
         ST_DIV_R: begin
            if (status.div_done) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            // A lost data block closes with its local parity.
            if (step && status.loop_end) begin
               state_in = data_mode_ff ? ST_PARITY : ST_IDLE;
            end
         end
         ST_PARITY: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         ST_BAD: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load        = 1'b1;
               cmd.div_k_start = 1'b1;
            end
         end
         ST_DIV_K: begin
            cmd.nr_load = status.div_done;
         end
         ST_CLASSIFY: begin
            cmd.mode_load   = 1'b1;
            cmd.div_r_start = (status.mode == MODE_DATA) && !status.nr_zero;
         end
         ST_DIV_R: begin
            cmd.group_load = status.div_done;
         end
         ST_EMIT: begin
            cmd.advance     = step;
            cmd.push_member = !status.skip && status.out_free;
         end
         ST_PARITY: begin
            cmd.push_parity = status.out_free;
         end
         ST_BAD: begin
            cmd.push_bad = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         data_mode_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         data_mode_ff <= data_mode_in;
      end
   end

endmodule

>>> hdl/lrc_single_repair_plan_top.sv
// Top level of the single-failure repair planner for a local reconstruction code stripe.
// Depends on lrcsrp_pkg, lrcsrp_if, lrcsrp_csr, lrcsrp_dp and lrcsrp_ctrl.
//
// Usage
//   Write the stripe geometry (k data blocks, l local groups, g global parities) through
//   the APB port at byte addresses 0, 4 and 8 while the block is idle; pready is always high.
//   Offer the index of one lost block as a word on req_chan. The block answers with a run
//   of words on rsp_chan, each a (source block, GF(2^8) coefficient) pair, the final one
//   flagged by last. An index outside the stripe gives a single word with bad_index set.
//   A lost local parity with an empty group, or a lost global parity with k = 0, gives
//   no word at all.
// Throughput (no stall on rsp_chan)
//   One item at a time. The shared 6-step divider first divides k by l for every plan; a
//   lost data block in a group of nr needs a second division and has one skipped slot for
//   the lost block itself. Pairs then leave at one a cycle from the output register, but
//   for the skipped slot.
// Reset
//   Synchronous, active high; restores k = 6, l = 2, g = 2 and drops any plan in flight.
// Stalls
//   A stalled rsp_chan holds the output word and halts the sequencer only where it pushes;
//   req_chan is ready again as soon as the final pair sits in the output register.
module lrc_single_repair_plan_top (
   input  logic                                  clock,
   input  logic                                  reset,
   lrcsrp_req_if.sink                            req_chan,
   lrcsrp_rsp_if.source                          rsp_chan,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [lrcsrp_pkg::CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [lrcsrp_pkg::CSR_DATA_WIDTH-1:0] pwdata,
   output logic [lrcsrp_pkg::CSR_DATA_WIDTH-1:0] prdata,
   output logic                                  pready
);
   import lrcsrp_pkg::*;

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;
   logic       req_ready;

   // Geometry registers.
   lrcsrp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Sequencer: accept a word only when the previous plan has been handed over.
   lrcsrp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   assign req_chan.ready = req_ready;

   // Arithmetic, pair counter and output register.
   lrcsrp_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .failed_index (req_chan.failed_index),
      .cmd          (cmd),
      .status       (status),
      .rsp          (rsp_chan)
   );

`ifndef SYNTHESIS
   // One plan at a time: drop ready right after taking a word.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> !req_chan.ready)
      else $error("request taken while a plan is in flight");

   // An out-of-stripe answer is a lone, zeroed, final word.
   a_bad_word: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.bad_index |->
         rsp_chan.last && rsp_chan.source_index == '0 && rsp_chan.coefficient == '0)
      else $error("bad-index word malformed");

   // Every real repair pair carries a non-zero coefficient.
   a_coef_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.bad_index |-> rsp_chan.coefficient != '0)
      else $error("repair pair with zero coefficient");

   // No new pair may be loaded while the receiver stalls a pending one.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.ready |->
         !(cmd.push_member || cmd.push_parity || cmd.push_bad))
      else $error("output word overwritten under stall");
`endif

endmodule
